// ----- rtl/core/cce_pkg.sv -----
`timescale 1ns / 1ps

package cce_pkg;

  localparam int unsigned CrcW  = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 3;

  // width_select codes; the unused code selects 64 bits like WSEL_64
  localparam logic [1:0] WSEL_16 = 2'd0;
  localparam logic [1:0] WSEL_32 = 2'd1;
  localparam logic [1:0] WSEL_64 = 2'd2;

  typedef enum logic [AddrW-1:0] {
    CFG_WIDTH_SEL = 3'd0,
    CFG_POLY      = 3'd1,
    CFG_SEED      = 3'd2,
    CFG_REFLECT   = 3'd3,
    CFG_INVERT    = 3'd4
  } cfg_idx_e;

  localparam logic [1:0]      RST_WIDTH_SEL = WSEL_32;
  localparam logic [CrcW-1:0] RST_POLY      = 64'h0000_0000_04C1_1DB7;
  localparam logic [CrcW-1:0] RST_SEED      = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]      width_sel;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] seed;
    logic            reflect;
    logic            invert;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             first_item;
    logic             last_item;
    logic             use_message_seed;
    logic [CrcW-1:0]  message_seed;
  } item_t;

  function automatic logic [CrcW-1:0] width_mask(input logic [1:0] sel);
    logic [CrcW-1:0] m;
    case (sel)
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = b[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] rev64(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/configurable_crc_engine.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_stall_o  data_byte, has_byte, first/last_item, seeds
// out      source     out_valid_o/out_stall_i crc_value
// cfg      sink       cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// One byte per cycle sustained, unless a last word waits on a stalled result.
// Accept to result passes the input register, then the eight-step fold into crc_q and the result register.
// Reset clears the valid flags and the running CRC and returns the config registers to their defaults.
// A stalled result holds the input stage only when that stage carries a last word.

module configurable_crc_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cce_pkg::AddrW-1:0]    cfg_addr_i,
  input  logic [cce_pkg::CrcW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cce_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         has_byte_i,
  input  logic                         first_item_i,
  input  logic                         last_item_i,
  input  logic                         use_message_seed_i,
  input  logic [cce_pkg::CrcW-1:0]     message_seed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cce_pkg::CrcW-1:0]     crc_value_o
);
  import cce_pkg::*;

  cfg_t            cfg_q;
  item_t           s1_q;
  logic            s1_valid_q;
  logic            s1_move;
  logic            in_take;
  logic [CrcW-1:0] crc_q;
  logic [CrcW-1:0] crc_d;
  logic [CrcW-1:0] result_d;
  logic            out_valid_q;
  logic [CrcW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_sel <= RST_WIDTH_SEL;
      cfg_q.poly      <= RST_POLY;
      cfg_q.seed      <= RST_SEED;
      cfg_q.reflect   <= 1'b0;
      cfg_q.invert    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_WIDTH_SEL: cfg_q.width_sel <= cfg_wdata_i[1:0];
        CFG_POLY:      cfg_q.poly      <= cfg_wdata_i;
        CFG_SEED:      cfg_q.seed      <= cfg_wdata_i;
        CFG_REFLECT:   cfg_q.reflect   <= cfg_wdata_i[0];
        CFG_INVERT:    cfg_q.invert    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A word without last never waits on the output side.
  assign s1_move    = s1_valid_q && (!s1_q.last_item || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.data_byte        <= data_byte_i;
      s1_q.has_byte         <= has_byte_i;
      s1_q.first_item       <= first_item_i;
      s1_q.last_item        <= last_item_i;
      s1_q.use_message_seed <= use_message_seed_i;
      s1_q.message_seed     <= message_seed_i;
    end
  end

  cce_fold u_fold (
    .cfg_i    (cfg_q),
    .item_i   (s1_q),
    .crc_i    (crc_q),
    .crc_o    (crc_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (s1_move) begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_q.last_item) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_q.last_item) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_data_q;

`ifndef ASSERT_OFF
  a_empty_stage_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input stage");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_q.last_item |=> out_valid_o)
    else $error("last word moved without a result");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(s1_move && s1_q.last_item) |=> !out_valid_o)
    else $error("result shown twice");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(crc_q))
    else $error("held word lost or CRC changed while held");
`endif

endmodule

// ----- rtl/core/cce_fold.sv -----
`timescale 1ns / 1ps

module cce_fold (
  input  cce_pkg::cfg_t            cfg_i,
  input  cce_pkg::item_t           item_i,
  input  logic [cce_pkg::CrcW-1:0] crc_i,
  output logic [cce_pkg::CrcW-1:0] crc_o,
  output logic [cce_pkg::CrcW-1:0] result_o
);
  import cce_pkg::*;

  logic [CrcW-1:0]  mask;
  logic [CrcW-1:0]  start;
  logic [CrcW-1:0]  acc;
  logic [CrcW-1:0]  poly_al;
  logic [ByteW-1:0] byte_in;
  logic [CrcW-1:0]  fin;
  logic [CrcW-1:0]  fin_rev;

  assign mask    = width_mask(cfg_i.width_sel);
  assign byte_in = cfg_i.reflect ? rev8(item_i.data_byte) : item_i.data_byte;

  // Work MSB-aligned in 64 bits so the same eight steps serve every width.
  always_comb begin
    if (item_i.first_item) begin
      start = (item_i.use_message_seed ? item_i.message_seed : cfg_i.seed) & mask;
    end else begin
      start = crc_i & mask;
    end

    case (cfg_i.width_sel)
      WSEL_16: begin
        acc     = {start[15:0], 48'd0};
        poly_al = {cfg_i.poly[15:0], 48'd0};
      end
      WSEL_32: begin
        acc     = {start[31:0], 32'd0};
        poly_al = {cfg_i.poly[31:0], 32'd0};
      end
      default: begin
        acc     = start;
        poly_al = cfg_i.poly;
      end
    endcase

    if (item_i.has_byte) begin
      acc[CrcW-1 -: ByteW] = acc[CrcW-1 -: ByteW] ^ byte_in;
      for (int k = 0; k < ByteW; k++) begin
        acc = acc[CrcW-1] ? ((acc << 1) ^ poly_al) : (acc << 1);
      end
    end

    case (cfg_i.width_sel)
      WSEL_16: crc_o = {48'd0, acc[63:48]};
      WSEL_32: crc_o = {32'd0, acc[63:32]};
      default: crc_o = acc;
    endcase
  end

  assign fin     = crc_o ^ (cfg_i.invert ? mask : '0);
  assign fin_rev = rev64(fin);

  always_comb begin
    if (!cfg_i.reflect) begin
      result_o = fin;
    end else begin
      case (cfg_i.width_sel)
        WSEL_16: result_o = {48'd0, fin_rev[63:48]};
        WSEL_32: result_o = {32'd0, fin_rev[63:32]};
        default: result_o = fin_rev;
      endcase
    end
  end

endmodule
